>>> rtl/core/pac_pkg.sv
package pac_pkg;

  localparam int unsigned AngW   = 32;  // angles, gains, error
  localparam int unsigned DtW    = 24;  // time step, Q0.24
  localparam int unsigned SumW   = 23;  // integral, bounded by +-50.0 in Q16.16
  localparam int unsigned OpW    = 33;  // multiplier operand
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned TermW  = 48;  // P and I terms after the >>16
  localparam int unsigned DMagW  = 49;  // derivative magnitude, capped at 2^48
  localparam int unsigned DTermW = DMagW + 1;
  localparam int unsigned WideW  = 52;  // P + I + D before saturation
  localparam int unsigned DivW   = 72;  // |deriv_gain * diff| << 8
  localparam int unsigned DivSteps = DivW / 2;  // two quotient bits per cycle
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic signed [33:0] Ang180   = 34'sd11796480;
  localparam logic signed [33:0] Ang360   = 34'sd23592960;
  localparam logic signed [33:0] SumLimit = 34'sd3276800;

  localparam logic signed [WideW-1:0] WideMax = 52'sd2147483647;
  localparam logic signed [WideW-1:0] WideMin = -52'sd2147483648;

  typedef enum logic [1:0] {
    CfgPropGain  = 2'd0,
    CfgIntegGain = 2'd1,
    CfgDerivGain = 2'd2,
    CfgYawWrap   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MulProp    = 2'd0,  // prop_gain * error
    MulInteg   = 2'd1,  // error * time_step
    MulIntTerm = 2'd2,  // integ_gain * error_sum
    MulDeriv   = 2'd3   // deriv_gain * (error - last_error)
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     err_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     p_en;
    logic     sum_en;
    logic     i_en;
    logic     div_start;
    logic     last_en;
    logic     out_en;
  } pac_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic hold;
    logic div_busy;
  } pac_status_t;

  function automatic logic signed [AngW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic signed [AngW-1:0] r;
    if (x > WideMax) begin
      r = WideMax[AngW-1:0];
    end else if (x < WideMin) begin
      r = WideMin[AngW-1:0];
    end else begin
      r = x[AngW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pid_angle_controller_unit.sv
// Angle PID step in Q16.16. One item (target, measured, time step, hold) gives
// one drive beat. Items are processed one at a time: a normal step waits on
// the radix-4 divider that forms the derivative over the time step; a hold step
// skips the divider and a zero time step goes straight from the error to the
// result. A new item is accepted while the previous result still waits on
// out_stall. Gains and yaw_wrap must be written through the cfg port only while
// no item is in flight; the block itself does not enforce it. Reset clears them
// and the integral and previous-error state.
module pid_angle_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [pac_pkg::AngW-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [pac_pkg::AngW-1:0] target_angle,
  input  logic signed [pac_pkg::AngW-1:0] measured_angle,
  input  logic [pac_pkg::DtW-1:0]        time_step,
  input  logic                           hold,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [pac_pkg::AngW-1:0] drive
);
  import pac_pkg::*;

  pac_cmd_t    cmd;
  pac_status_t status;

  pac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pac_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .target_angle   (target_angle),
    .measured_angle (measured_angle),
    .time_step      (time_step),
    .hold           (hold),
    .cmd            (cmd),
    .status         (status),
    .drive          (drive)
  );

endmodule

>>> rtl/core/pac_div.sv
module pac_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pac_pkg::DivW-1:0]     dividend,
  input  logic [pac_pkg::DtW-1:0]      divisor,
  output logic                         busy,
  output logic [pac_pkg::DivW-1:0]     quotient
);
  import pac_pkg::*;

  // restoring division, radix 4: dividend shifts out the top, quotient in at the bottom
  logic [DivW-1:0]    acc;
  logic [DtW-1:0]     rem;
  logic [DivCntW-1:0] count;

  logic [DtW:0]    r1, r2;
  logic [DtW:0]    r1s, r2s;
  logic            ge1, ge2;
  logic [DivW-1:0] acc_next;
  logic [DtW-1:0]  rem_next;

  always_comb begin
    r1  = {rem, acc[DivW-1]};
    ge1 = r1 >= {1'b0, divisor};
    r1s = ge1 ? r1 - {1'b0, divisor} : r1;
    r2  = {r1s[DtW-1:0], acc[DivW-2]};
    ge2 = r2 >= {1'b0, divisor};
    r2s = ge2 ? r2 - {1'b0, divisor} : r2;
    acc_next = {acc[DivW-3:0], ge1, ge2};
    rem_next = r2s[DtW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DivCntW'(DivSteps - 1);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient = acc;

endmodule

>>> rtl/core/pac_datapath.sv
module pac_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [pac_pkg::AngW-1:0]      cfg_data,
  input  logic signed [pac_pkg::AngW-1:0] target_angle,
  input  logic signed [pac_pkg::AngW-1:0] measured_angle,
  input  logic [pac_pkg::DtW-1:0]       time_step,
  input  logic                          hold,
  input  pac_pkg::pac_cmd_t             cmd,
  output pac_pkg::pac_status_t          status,
  output logic signed [pac_pkg::AngW-1:0] drive
);
  import pac_pkg::*;

  // configuration
  logic signed [AngW-1:0] prop_gain, integ_gain, deriv_gain;
  logic                   yaw_wrap;

  // controller state
  logic signed [SumW-1:0] error_sum;
  logic signed [AngW-1:0] last_error;

  // item scratch
  logic signed [AngW-1:0]   tgt, meas, err;
  logic [DtW-1:0]           dt;
  logic                     hold_q;
  logic signed [ProdW-1:0]  prod;
  logic signed [TermW-1:0]  p_term, i_term;
  logic                     d_neg;

  logic signed [33:0]       raw_err, wrap_err;
  logic signed [OpW-1:0]    op_a, op_b;
  logic signed [33:0]       sum_wide, sum_clamped;
  logic [ProdW-1:0]         prod_abs;
  logic                     div_busy;
  logic [DivW-1:0]          quotient;
  logic [DMagW-1:0]         d_mag;
  logic signed [DTermW-1:0] d_term;
  logic signed [WideW-1:0]  total;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      yaw_wrap   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CfgPropGain:  prop_gain  <= cfg_data;
        CfgIntegGain: integ_gain <= cfg_data;
        CfgDerivGain: deriv_gain <= cfg_data;
        CfgYawWrap:   yaw_wrap   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // error, one turn of yaw wrap, then held to 32 bits
  always_comb begin
    raw_err  = 34'(tgt) - 34'(meas);
    wrap_err = raw_err;
    if (yaw_wrap && raw_err > Ang180) begin
      wrap_err = raw_err - Ang360;
    end else if (yaw_wrap && raw_err < -Ang180) begin
      wrap_err = raw_err + Ang360;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MulProp: begin
        op_a = OpW'(prop_gain);
        op_b = OpW'(err);
      end
      MulInteg: begin
        op_a = OpW'(err);
        op_b = $signed({{(OpW-DtW){1'b0}}, dt});
      end
      MulIntTerm: begin
        op_a = OpW'(integ_gain);
        op_b = OpW'(error_sum);
      end
      MulDeriv: begin
        op_a = OpW'(deriv_gain);
        op_b = OpW'(err) - OpW'(last_error);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // integral step: floor(err*dt >> 24), then clamp to +-50.0
  always_comb begin
    sum_wide = 34'(error_sum) + 34'($signed(prod[56:24]));
    if (sum_wide > SumLimit) begin
      sum_clamped = SumLimit;
    end else if (sum_wide < -SumLimit) begin
      sum_clamped = -SumLimit;
    end else begin
      sum_clamped = sum_wide;
    end
  end

  assign prod_abs = prod[ProdW-1] ? ProdW'(-prod) : prod;

  pac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({prod_abs[63:0], 8'b0}),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    d_mag  = (|quotient[DivW-1:DMagW-1]) ? {1'b1, {(DMagW-1){1'b0}}}
                                         : {1'b0, quotient[DMagW-2:0]};
    d_term = d_neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
    total  = WideW'(p_term) + WideW'(i_term) + (hold_q ? '0 : WideW'(d_term));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      if (cmd.sum_en) begin
        error_sum <= sum_clamped[SumW-1:0];
      end
      if (cmd.last_en) begin
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt    <= target_angle;
      meas   <= measured_angle;
      dt     <= time_step;
      hold_q <= hold;
    end
    if (cmd.err_en) begin
      err <= sat32(WideW'(wrap_err));
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.p_en) begin
      p_term <= $signed(prod[63:16]);
    end
    if (cmd.i_en) begin
      i_term <= $signed(prod[63:16]);
    end
    if (cmd.div_start) begin
      d_neg <= prod[ProdW-1];
    end
    if (cmd.out_en) begin
      drive <= (dt == '0) ? '0 : sat32(total);
    end
  end

  assign status.dt_zero  = (dt == '0);
  assign status.hold     = hold_q;
  assign status.div_busy = div_busy;

endmodule

>>> rtl/core/pac_ctrl.sv
module pac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pac_pkg::pac_status_t status,
  output pac_pkg::pac_cmd_t    cmd
);
  import pac_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ERR  = 10'b0000000010,
    S_MP   = 10'b0000000100,
    S_MINT = 10'b0000001000,
    S_SUM  = 10'b0000010000,
    S_MI   = 10'b0000100000,
    S_DIVW = 10'b0001000000,
    S_MH   = 10'b0010000000,
    S_HI   = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MulProp;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_next = status.dt_zero ? S_DONE : S_MP;
      end
      S_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MulProp;
        state_next  = status.hold ? S_MH : S_MINT;
      end
      S_MINT: begin
        cmd.p_en    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MulInteg;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MulDeriv;
        state_next  = S_MI;
      end
      S_MI: begin
        // divider takes the D product while the multiplier moves on to I
        cmd.div_start = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MulIntTerm;
        cmd.last_en   = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        cmd.i_en = 1'b1;
        if (!status.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_MH: begin
        cmd.p_en    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MulIntTerm;
        cmd.last_en = 1'b1;
        state_next  = S_HI;
      end
      S_HI: begin
        cmd.i_en   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_en |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // a new result beat only follows the final state
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("out_valid rose outside S_DONE");

  // the divider is running for the first wait cycle
  a_div_started: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVW && $past(state == S_MI)) |-> status.div_busy)
    else $error("divider not started");

  // state is touched only on the normal or hold paths, never on a zero time step
  a_state_guard: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum_en || cmd.last_en) |-> !status.dt_zero)
    else $error("state update on zero time step");
`endif

endmodule

>>> test/tb_pid_angle_controller_unit.sv
`timescale 1ns / 1ps

module tb_pid_angle_controller_unit;
  import pac_pkg::*;

  localparam longint Deg = 65536;
  localparam longint Deg180 = 180 * Deg;
  localparam longint Deg360 = 360 * Deg;
  localparam longint IntegCap = 50 * Deg;
  localparam longint S32Hi = 64'sd2147483647;
  localparam longint S32Lo = -64'sd2147483648;
  localparam longint unsigned DerivCap = 64'd1 << 48;
  localparam logic [31:0] GainMax = 32'h7FFF_FFFF;
  localparam logic [31:0] GainMin = 32'h8000_0000;

  // Predicts one drive beat per accepted item and checks beats in order.
  class drive_scoreboard;
    logic signed [31:0] kp, ki, kd;
    bit wrap;
    longint integ, prev_err;
    logic [31:0] drive_q[$];
    int unsigned mismatches;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      wrap = 0;
      integ = 0;
      prev_err = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [31:0] val);
      case (idx)
        CfgPropGain:  kp = val;
        CfgIntegGain: ki = val;
        CfgDerivGain: kd = val;
        CfgYawWrap:   wrap = val[0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > S32Hi) return S32Hi;
      if (x < S32Lo) return S32Lo;
      return x;
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void note_input(logic signed [31:0] tgt, logic signed [31:0] meas,
                             logic [23:0] dt, logic hld);
      longint e, p_t, i_t, d_t, s, prod;
      longint unsigned mag, q, r, v;
      bit neg;
      if (dt == 0) begin
        drive_q.push_back(32'd0);
        return;
      end
      e = longint'(tgt) - longint'(meas);
      if (wrap) begin
        if (e > Deg180) e -= Deg360;
        else if (e < -Deg180) e += Deg360;
      end
      e = clip32(e);
      p_t = (longint'(kp) * e) >>> 16;
      if (hld) begin
        prev_err = e;
        i_t = (longint'(ki) * integ) >>> 16;
        drive_q.push_back(32'(clip32(p_t + i_t)));
        return;
      end
      s = integ + ((e * longint'(dt)) >>> 24);
      if (s > IntegCap) s = IntegCap;
      if (s < -IntegCap) s = -IntegCap;
      integ = s;
      i_t = (longint'(ki) * integ) >>> 16;
      prod = longint'(kd) * (e - prev_err);
      neg = prod < 0;
      if (neg) mag = -prod;
      else mag = prod;
      q = mag / dt;
      r = mag % dt;
      if (q >= DerivCap) begin
        v = DerivCap;
      end else begin
        v = (q << 8) + ((r << 8) / dt);
        if (v > DerivCap) v = DerivCap;
      end
      d_t = neg ? -longint'(v) : longint'(v);
      prev_err = e;
      drive_q.push_back(32'(clip32(p_t + i_t + d_t)));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_drive(logic [31:0] got);
      logic [31:0] exp_drive;
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("drive beat 0x%08h with no item pending", got));
        return;
      end
      exp_drive = drive_q.pop_front();
      if (got !== exp_drive)
        report_mismatch($sformatf("drive 0x%08h, predicted 0x%08h", got, exp_drive));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [AngW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AngW-1:0] target_angle = '0;
  logic signed [AngW-1:0] measured_angle = '0;
  logic [DtW-1:0] time_step = '0;
  logic hold = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AngW-1:0] drive;

  bit idle_on = 1'b1;
  drive_scoreboard sb = new();

  pid_angle_controller_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .target_angle(target_angle),
    .measured_angle(measured_angle),
    .time_step(time_step),
    .hold(hold),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive(drive)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_input(target_angle, measured_angle, time_step, hold);
      if (out_valid && !out_stall)
        sb.check_drive(drive);
    end
  end

  // receiver stalls in short bursts
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  task send_item(logic [31:0] tgt, logic [31:0] meas, logic [23:0] dt, logic hld);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_angle <= tgt;
    measured_angle <= meas;
    time_step <= dt;
    hold <= hld;
    do @(posedge clk); while (in_stall);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task set_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd, logic [31:0] yaw);
    logic [31:0] vals[4];
    cfg_index_t idx;
    vals = '{kp, ki, kd, yaw};
    for (int k = 0; k < 4; k++) begin
      idx = cfg_index_t'(k);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[k];
      sb.write_reg(idx, vals[k]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return GainMax;
      2: return GainMin;
      3: return 32'd0;
      default: return 32'($urandom_range(0, 16 * Deg)) - 32'(8 * Deg);
    endcase
  endfunction

  function logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 800 * Deg)) - 32'(400 * Deg);
      2: return 32'($urandom_range(0, 20 * Deg)) - 32'(10 * Deg);
      default: return 32'($urandom_range(0, 400 * Deg)) - 32'(200 * Deg);
    endcase
  endfunction

  task send_random_item();
    logic [31:0] tgt, meas;
    logic [23:0] dt;
    logic hld;
    tgt = pick_angle();
    meas = ($urandom_range(0, 2) == 0) ? tgt + 32'($urandom_range(0, 4 * Deg)) - 32'(2 * Deg)
                                       : pick_angle();
    case ($urandom_range(0, 15))
      0: dt = 24'd0;
      1, 2, 3: dt = 24'($urandom);
      4: dt = 24'($urandom_range(1, 16));
      default: dt = 24'($urandom_range(1, 40000));
    endcase
    hld = ($urandom_range(0, 7) == 0);
    send_item(tgt, meas, dt, hld);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset gains: drive stays zero, integral still moves
    send_item(32'(10 * Deg), 32'd0, 24'h010000, 1'b0);
    send_item(32'(-3 * Deg), 32'(4 * Deg), 24'h001000, 1'b0);
    drain();

    set_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'd0);
    send_item(32'(10 * Deg), 32'd0, 24'h010000, 1'b0);
    send_item(32'(20 * Deg), 32'(5 * Deg), 24'd0, 1'b0);   // zero dt
    send_item(32'(20 * Deg), 32'(5 * Deg), 24'd0, 1'b1);   // zero dt ignores hold
    send_item(32'(30 * Deg), 32'd0, 24'h100000, 1'b1);     // hold
    send_item(GainMax, GainMin, 24'hFFFFFF, 1'b0);         // error saturates, sum to +50
    send_item(GainMax, GainMin, 24'hFFFFFF, 1'b0);
    send_item(GainMin, GainMax, 24'hFFFFFF, 1'b0);         // sum swings to -50
    send_item(GainMin, GainMax, 24'd1, 1'b0);              // tiny dt
    send_item(32'd0, 32'd0, 24'd1, 1'b0);                  // big error change over tiny dt
    send_item(32'(-5 * Deg), 32'(5 * Deg), 24'h000100, 1'b0);
    drain();

    set_config(32'h0002_0000, 32'h0001_0000, 32'h0000_1000, 32'hFFFF_FFFF);
    send_item(32'(190 * Deg), 32'd0, 24'h004000, 1'b0);
    send_item(32'(-190 * Deg), 32'd0, 24'h004000, 1'b0);
    send_item(32'(180 * Deg), 32'd0, 24'h004000, 1'b0);    // right at the wrap edge
    send_item(32'(-180 * Deg), 32'd0, 24'h004000, 1'b0);
    send_item(32'(170 * Deg), 32'(-170 * Deg), 24'h004000, 1'b1);
    send_item(GainMax, GainMin, 24'h004000, 1'b0);         // wrap then saturate
    send_item(GainMin, GainMax, 24'h004000, 1'b0);
    drain();

    set_config(GainMax, GainMin, GainMin, 32'd0);
    send_item(GainMax, GainMin, 24'hFFFFFF, 1'b0);
    send_item(GainMin, GainMax, 24'd1, 1'b0);
    send_item(32'd1, 32'd0, 24'd1, 1'b1);
    send_item(32'd0, 32'd0, 24'hFFFFFF, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_config(pick_gain(), pick_gain(), pick_gain(),
                 {31'($urandom), 1'($urandom_range(0, 1))});
      idle_on = (ph < 5) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 70; n++) begin
        send_random_item();
        if ($urandom_range(0, 63) == 0) drain();
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
